[design/mwf_pkg.sv]
// Package for the 3x3 morphology window filter.
// Holds pixel, window, context and result types, register codes and the
// neighborhood evaluation function. No dependencies.
package mwf_pkg;

    typedef logic [7:0] pix_t;

    // 3x3 neighborhood, index = row*3 + col, row 0 above, col 0 left
    typedef pix_t [8:0] patch_t;

    typedef enum logic [1:0] {
        MODE_DILATE  = 2'd0,
        MODE_ERODE   = 2'd1,
        MODE_MAXFILL = 2'd2,
        MODE_PASS    = 2'd3
    } mode_t;

    localparam logic [1:0] REG_OP_MODE      = 2'd0;
    localparam logic [1:0] REG_FRAME_WIDTH  = 2'd1;
    localparam logic [1:0] REG_FRAME_HEIGHT = 2'd2;

    localparam pix_t PIX_MAX = 8'd255;

    // What one accepted pixel causes, worked out from the raster position
    typedef struct packed {
        logic       e1;         // emit (row-1, col-1)
        logic       e2;         // emit (row-1, last col)
        logic       e3;         // emit (row, col) on the bottom row
        logic       first_row;  // row == 1
        logic       first_col;  // col == 1
        logic       col0;       // col == 0
        logic       last_col;   // col == width-1
        logic [9:0] row_m1;
        logic [9:0] row;
        logic [9:0] col_m1;
        logic [9:0] col;
    } ctx_t;

    typedef struct packed {
        logic       frame_done;
        logic       run_last;
        logic [9:0] col;
        logic [9:0] row;
        pix_t       pixel;
    } result_t;

    function automatic pix_t eval_pixel(patch_t p, logic top, logic bot, logic lft,
                                        logic rgt, mode_t mode);
        logic [8:0] sel;
        logic       any_zero;
        logic       any_set;
        pix_t       mx;
        pix_t       ctr;
        pix_t       res;
        ctr      = p[4];
        any_zero = 1'b0;
        any_set  = 1'b0;
        mx       = '0;
        if ((top || bot) && (lft || rgt)) begin
            // corner: inner diagonal only
            if (top && lft)       sel = 9'b100_000_000;
            else if (top)         sel = 9'b001_000_000;
            else if (lft)         sel = 9'b000_000_100;
            else                  sel = 9'b000_000_001;
        end else if (top) begin
            sel = 9'b111_000_000;
        end else if (bot) begin
            sel = 9'b000_000_111;
        end else if (lft) begin
            sel = 9'b100_100_100;
        end else if (rgt) begin
            sel = 9'b001_001_001;
        end else begin
            sel = 9'b111_101_111;
        end
        for (int i = 0; i < 9; i++) begin
            if (sel[i]) begin
                if (p[i] == '0) any_zero = 1'b1;
                else            any_set  = 1'b1;
                if (p[i] > mx)  mx = p[i];
            end
        end
        unique case (mode)
            MODE_DILATE:  res = (ctr == '0 && any_set) ? PIX_MAX : ctr;
            MODE_ERODE:   res = (ctr != '0 && any_zero) ? '0 : ctr;
            MODE_MAXFILL: res = (ctr == '0) ? mx : ctr;
            MODE_PASS:    res = ctr;
            default:      res = ctr;
        endcase
        return res;
    endfunction

endpackage

[design/mwf_line_buf.sv]
// Two line stores (rows y-2 and y-1) with registered reads.
// Store b has a second read port at the next column. Uses mwf_pkg.
module mwf_line_buf #(
    parameter int ADDR_W = 10,
    parameter int DEPTH  = 1024
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               rd_en,
    input  logic [ADDR_W-1:0]  rd_addr,
    input  logic               wb_en,
    input  logic [ADDR_W-1:0]  wb_addr,
    input  mwf_pkg::pix_t      wb_pix,
    output mwf_pkg::pix_t      a_q,
    output mwf_pkg::pix_t      b_q,
    output mwf_pkg::pix_t      bn_q
);

    mwf_pkg::pix_t line_a_reg [DEPTH];
    mwf_pkg::pix_t line_b_reg [DEPTH];
    mwf_pkg::pix_t a_q_reg;
    mwf_pkg::pix_t b_q_reg;
    mwf_pkg::pix_t bn_q_reg;
    logic [ADDR_W-1:0] rd_addr_n;

    assign rd_addr_n = rd_addr + ADDR_W'(1);

    always_ff @(posedge aclk) begin
        if (rd_en) begin
            a_q_reg  <= line_a_reg[rd_addr];
            b_q_reg  <= line_b_reg[rd_addr];
            bn_q_reg <= line_b_reg[rd_addr_n];
        end
    end

    // row y-1 moves down to a, the new pixel goes to b
    always_ff @(posedge aclk) begin
        if (wb_en) begin
            line_a_reg[wb_addr] <= b_q_reg;
            line_b_reg[wb_addr] <= wb_pix;
        end
    end

    assign a_q  = a_q_reg;
    assign b_q  = b_q_reg;
    assign bn_q = bn_q_reg;

    a_no_rw_overlap: assert property (@(posedge aclk) disable iff (!aresetn)
        rd_en && wb_en |-> (rd_addr != wb_addr) && (rd_addr_n != wb_addr))
        else $error("line store read and write-back hit the same column");

endmodule

[design/mwf_window.sv]
// 3x3 window registers and evaluation of up to three results per pixel.
// Uses mwf_pkg (types, eval_pixel).
module mwf_window (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  adv,
    input  mwf_pkg::pix_t         a_q,
    input  mwf_pkg::pix_t         b_q,
    input  mwf_pkg::pix_t         bn_q,
    input  mwf_pkg::pix_t         pix,
    input  mwf_pkg::ctx_t         ctx,
    input  mwf_pkg::mode_t        mode,
    output mwf_pkg::result_t [2:0] res,
    output logic [1:0]            res_n
);

    mwf_pkg::patch_t  window_reg;
    mwf_pkg::patch_t  window_next;
    mwf_pkg::patch_t  p2;
    mwf_pkg::patch_t  p3;
    mwf_pkg::result_t r1;
    mwf_pkg::result_t r2;
    mwf_pkg::result_t r3;

    always_comb begin
        window_next[0] = window_reg[1];
        window_next[1] = window_reg[2];
        window_next[2] = a_q;
        window_next[3] = window_reg[4];
        window_next[4] = window_reg[5];
        window_next[5] = b_q;
        window_next[6] = window_reg[7];
        window_next[7] = window_reg[8];
        window_next[8] = pix;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            window_reg <= '0;
        end else if (adv) begin
            window_reg <= window_next;
        end
    end

    // right-column pixel of the row above, zero column past the edge
    always_comb begin
        p2    = '0;
        p2[0] = window_next[1];
        p2[1] = window_next[2];
        p2[3] = window_next[4];
        p2[4] = window_next[5];
        p2[6] = window_next[7];
        p2[7] = window_next[8];
    end

    // bottom-row pixel, evaluated as it arrives
    always_comb begin
        p3    = '0;
        p3[0] = window_next[4];
        p3[1] = window_next[5];
        p3[2] = ctx.last_col ? '0 : bn_q;
        p3[3] = window_next[7];
        p3[4] = pix;
    end

    always_comb begin
        r1.pixel      = mwf_pkg::eval_pixel(window_next, ctx.first_row, 1'b0,
                                            ctx.first_col, 1'b0, mode);
        r1.row        = ctx.row_m1;
        r1.col        = ctx.col_m1;
        r1.run_last   = !ctx.e2 && !ctx.e3;
        r1.frame_done = 1'b0;

        r2.pixel      = mwf_pkg::eval_pixel(p2, ctx.first_row, 1'b0, 1'b0, 1'b1, mode);
        r2.row        = ctx.row_m1;
        r2.col        = ctx.col;
        r2.run_last   = !ctx.e3;
        r2.frame_done = 1'b0;

        r3.pixel      = mwf_pkg::eval_pixel(p3, 1'b0, 1'b1, ctx.col0, ctx.last_col, mode);
        r3.row        = ctx.row;
        r3.col        = ctx.col;
        r3.run_last   = 1'b1;
        r3.frame_done = ctx.last_col;
    end

    always_comb begin
        res[0] = ctx.e1 ? r1 : (ctx.e2 ? r2 : r3);
        res[1] = (ctx.e1 && ctx.e2) ? r2 : r3;
        res[2] = r3;
        res_n  = 2'(ctx.e1) + 2'(ctx.e2) + 2'(ctx.e3);
    end

endmodule

[design/mwf_out_queue.sv]
// Result slots for one pixel's results and the output register.
// Drains one word per cycle while m_tready is high. Uses mwf_pkg (result_t).
module mwf_out_queue (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   load,
    input  mwf_pkg::result_t [2:0] items,
    input  logic [1:0]             n,
    output logic                   ready,
    output logic                   m_tvalid,
    input  logic                   m_tready,
    output logic [31:0]            m_tdata,   // pixel_out[7:0], out_row[17:8], out_col[27:18]
    output logic                   m_tlast,
    output logic                   m_tuser    // frame_done
);

    mwf_pkg::result_t [2:0] slots_reg;
    mwf_pkg::result_t [2:0] slots_next;
    logic [1:0]             cnt_reg;
    logic [1:0]             cnt_next;
    mwf_pkg::result_t       out_reg;
    mwf_pkg::result_t       out_next;
    logic                   out_valid_reg;
    logic                   out_valid_next;
    logic                   take;

    assign take  = (cnt_reg != 2'd0) && (!out_valid_reg || m_tready);
    assign ready = (cnt_reg == 2'd0) || (cnt_reg == 2'd1 && take);

    always_comb begin
        slots_next = slots_reg;
        cnt_next   = cnt_reg;
        if (load) begin
            slots_next = items;
            cnt_next   = n;
        end else if (take) begin
            slots_next[0] = slots_reg[1];
            slots_next[1] = slots_reg[2];
            cnt_next      = cnt_reg - 2'd1;
        end
    end

    always_comb begin
        out_next       = take ? slots_reg[0] : out_reg;
        out_valid_next = take ? 1'b1 : (m_tready ? 1'b0 : out_valid_reg);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg       <= 2'd0;
            out_valid_reg <= 1'b0;
        end else begin
            cnt_reg       <= cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        slots_reg <= slots_next;
        out_reg   <= out_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {4'd0, out_reg.col, out_reg.row, out_reg.pixel};
    assign m_tlast  = out_reg.run_last;
    assign m_tuser  = out_reg.frame_done;

    a_done_is_last: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser |-> m_tlast)
        else $error("frame end word without run end");

endmodule

[design/morph_window_3x3_filter.sv]
// 3x3 morphology filter (dilate, erode, max fill, pass) on a raster pixel stream.
// Path: a pixel's words pass the stage-1 register and the result slots to the output register.
// Throughput: one pixel per clock with m_tready high and at most one word per pixel; row ends
// and bottom-row pixels past col 0 yield 2 or 3 words, bounded by the single output port.
// Reset: synchronous, active low; clears counters, window, pipeline and config to defaults.
// Line stores are not cleared; entries are always written before they reach an output.
module morph_window_3x3_filter #(
    parameter int MAX_WIDTH  = 1024,
    parameter int MAX_HEIGHT = 1024
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,    // pixel_in[7:0]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,    // pixel_out[7:0], out_row[17:8], out_col[27:18]
    output logic        m_tlast,    // run_last
    output logic        m_tuser,    // frame_done
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    localparam int XW  = $clog2(MAX_WIDTH);
    localparam int YW  = $clog2(MAX_HEIGHT);
    localparam int XCW = XW + 1;
    localparam int YCW = YW + 1;

    logic [1:0]  op_mode_reg;
    logic [10:0] frame_width_reg;
    logic [10:0] frame_height_reg;
    logic        cfg_wr;
    logic        geo_wr;

    logic [XCW-1:0] w_eff;
    logic [YCW-1:0] h_eff;
    logic [XCW-1:0] w_m1;
    logic [YCW-1:0] h_m1;
    logic [XW-1:0]  w_last;
    logic [YW-1:0]  h_last;

    logic [XW-1:0] col_reg;
    logic [XW-1:0] col_next;
    logic [YW-1:0] row_reg;
    logic [YW-1:0] row_next;
    logic [XW-1:0] col_m1;
    logic [YW-1:0] row_m1;

    logic          s_accept;
    logic          s1_valid_reg;
    logic          s1_valid_next;
    logic          s1_adv;
    mwf_pkg::ctx_t ctx_s0;
    mwf_pkg::ctx_t ctx_s1_reg;
    mwf_pkg::pix_t pix_s1_reg;
    logic [XW-1:0] x_s1_reg;

    mwf_pkg::pix_t          a_q;
    mwf_pkg::pix_t          b_q;
    mwf_pkg::pix_t          bn_q;
    mwf_pkg::result_t [2:0] res;
    logic [1:0]             res_n;
    logic                   q_ready;

    // configuration
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;
    assign geo_wr = cfg_wr && (paddr[3:2] == mwf_pkg::REG_FRAME_WIDTH ||
                               paddr[3:2] == mwf_pkg::REG_FRAME_HEIGHT);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            op_mode_reg      <= 2'd0;
            frame_width_reg  <= 11'd80;
            frame_height_reg <= 11'd60;
        end else if (cfg_wr) begin
            unique case (paddr[3:2])
                mwf_pkg::REG_OP_MODE:      op_mode_reg      <= pwdata[1:0];
                mwf_pkg::REG_FRAME_WIDTH:  frame_width_reg  <= pwdata[10:0];
                mwf_pkg::REG_FRAME_HEIGHT: frame_height_reg <= pwdata[10:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        prdata = '0;
        unique case (paddr[3:2])
            mwf_pkg::REG_OP_MODE:      prdata = {30'd0, op_mode_reg};
            mwf_pkg::REG_FRAME_WIDTH:  prdata = {21'd0, frame_width_reg};
            mwf_pkg::REG_FRAME_HEIGHT: prdata = {21'd0, frame_height_reg};
            default:                   prdata = '0;
        endcase
    end

    // effective geometry, clamped to [3, MAX]
    always_comb begin
        if (frame_width_reg < 11'd3)                  w_eff = XCW'(3);
        else if (32'(frame_width_reg) > MAX_WIDTH)    w_eff = XCW'(MAX_WIDTH);
        else                                          w_eff = XCW'(frame_width_reg);
        if (frame_height_reg < 11'd3)                 h_eff = YCW'(3);
        else if (32'(frame_height_reg) > MAX_HEIGHT)  h_eff = YCW'(MAX_HEIGHT);
        else                                          h_eff = YCW'(frame_height_reg);
    end

    assign w_m1   = w_eff - XCW'(1);
    assign h_m1   = h_eff - YCW'(1);
    assign w_last = w_m1[XW-1:0];
    assign h_last = h_m1[YW-1:0];

    // raster position of the next input pixel
    assign s_accept = s_tvalid && s_tready;

    always_comb begin
        col_next = col_reg;
        row_next = row_reg;
        if (geo_wr) begin
            col_next = '0;
            row_next = '0;
        end else if (s_accept) begin
            if (col_reg == w_last) begin
                col_next = '0;
                row_next = (row_reg == h_last) ? '0 : row_reg + YW'(1);
            end else begin
                col_next = col_reg + XW'(1);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            col_reg <= '0;
            row_reg <= '0;
        end else begin
            col_reg <= col_next;
            row_reg <= row_next;
        end
    end

    assign col_m1 = col_reg - XW'(1);
    assign row_m1 = row_reg - YW'(1);

    always_comb begin
        ctx_s0.e1        = (row_reg != '0) && (col_reg != '0);
        ctx_s0.e2        = (row_reg != '0) && (col_reg == w_last);
        ctx_s0.e3        = (row_reg == h_last);
        ctx_s0.first_row = (row_reg == YW'(1));
        ctx_s0.first_col = (col_reg == XW'(1));
        ctx_s0.col0      = (col_reg == '0);
        ctx_s0.last_col  = (col_reg == w_last);
        ctx_s0.row_m1    = 10'(row_m1);
        ctx_s0.row       = 10'(row_reg);
        ctx_s0.col_m1    = 10'(col_m1);
        ctx_s0.col       = 10'(col_reg);
    end

    // stage 1: line store read data lands, window shifts on advance
    assign s1_adv   = s1_valid_reg && q_ready;
    assign s_tready = !s1_valid_reg || q_ready;

    always_comb begin
        s1_valid_next = s1_valid_reg;
        if (s_accept)    s1_valid_next = 1'b1;
        else if (s1_adv) s1_valid_next = 1'b0;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
        end else begin
            s1_valid_reg <= s1_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_accept) begin
            ctx_s1_reg <= ctx_s0;
            pix_s1_reg <= s_tdata;
            x_s1_reg   <= col_reg;
        end
    end

    mwf_line_buf #(
        .ADDR_W (XW),
        .DEPTH  (MAX_WIDTH)
    ) u_line_buf (
        .aclk    (aclk),
        .aresetn (aresetn),
        .rd_en   (s_accept),
        .rd_addr (col_reg),
        .wb_en   (s1_adv),
        .wb_addr (x_s1_reg),
        .wb_pix  (pix_s1_reg),
        .a_q     (a_q),
        .b_q     (b_q),
        .bn_q    (bn_q)
    );

    mwf_window u_window (
        .aclk    (aclk),
        .aresetn (aresetn),
        .adv     (s1_adv),
        .a_q     (a_q),
        .b_q     (b_q),
        .bn_q    (bn_q),
        .pix     (pix_s1_reg),
        .ctx     (ctx_s1_reg),
        .mode    (mwf_pkg::mode_t'(op_mode_reg)),
        .res     (res),
        .res_n   (res_n)
    );

    mwf_out_queue u_out_queue (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .load     (s1_adv),
        .items    (res),
        .n        (res_n),
        .ready    (q_ready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast),
        .m_tuser  (m_tuser)
    );

    a_pos_in_frame: assert property (@(posedge aclk) disable iff (!aresetn)
        (col_reg <= w_last) && (row_reg <= h_last))
        else $error("raster position outside the frame");

    a_row_end_has_pixel: assert property (@(posedge aclk) disable iff (!aresetn)
        s1_valid_reg && ctx_s1_reg.e2 |-> ctx_s1_reg.e1)
        else $error("row end result without its regular result");

endmodule

[dv/morph_window_3x3_filter_tb.sv]
// Self-checking testbench for morph_window_3x3_filter: streams pixel words in, checks each
// filtered result word against an in-bench 3x3 neighborhood predictor, programs over APB.
// Depends on mwf_pkg and the morph_window_3x3_filter RTL.
module morph_window_3x3_filter_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int MAX_DIM      = 1024;
    localparam int SETTLE_CYCLES = 16;
    localparam int MAX_REPORTS  = 10;

    logic        aclk    = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata  = 8'd0;     // pixel_in[7:0]
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [31:0] m_tdata;             // pixel_out[7:0], out_row[17:8], out_col[27:18]
    logic        m_tlast;             // run_last
    logic        m_tuser;             // frame_done
    logic        psel    = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite  = 1'b0;
    logic [3:0]  paddr   = 4'd0;
    logic [31:0] pwdata  = 32'd0;
    logic [31:0] prdata;
    logic        pready;

    morph_window_3x3_filter uut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast),
        .m_tuser  (m_tuser),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    always begin
        #10 aclk = 1'b1;
        #10 aclk = 1'b0;
    end

    // predictor state
    mwf_pkg::mode_t cur_mode = mwf_pkg::MODE_DILATE;
    logic [10:0] width_reg  = 11'd80;
    logic [10:0] height_reg = 11'd60;
    int unsigned cur_row    = 0;
    int unsigned cur_col    = 0;
    bit [7:0]    older_row [MAX_DIM];   // row y-2
    bit [7:0]    prev_row  [MAX_DIM];   // row y-1
    mwf_pkg::pix_t nbhd    [9] = '{default: 8'd0};

    mwf_pkg::result_t expected_words [$];
    int          error_count = 0;
    bit          tx_steady = 1'b0;
    bit          rx_steady = 1'b0;
    int          rx_hold   = 0;

    bit [7:0] directed_frames [3][9] = '{
        '{8'd0,   8'd0,   8'd0,   8'd0,   8'd255, 8'd0,   8'd0,   8'd0,   8'd1},
        '{8'd255, 8'd255, 8'd255, 8'd255, 8'd0,   8'd255, 8'd1,   8'd128, 8'd255},
        '{8'd0,   8'd7,   8'd9,   8'd0,   8'd50,  8'd255, 8'd3,   8'd0,   8'd0}
    };
    mwf_pkg::mode_t directed_modes [3] = '{mwf_pkg::MODE_DILATE, mwf_pkg::MODE_ERODE,
                                           mwf_pkg::MODE_MAXFILL};

    function automatic int unsigned clamp_geom(input logic [10:0] v);
        if (v < 11'd3)
            return 3;
        if (v > 11'(MAX_DIM))
            return MAX_DIM;
        return int'(v);
    endfunction

    function automatic mwf_pkg::pix_t neighborhood_value(input mwf_pkg::pix_t p [9],
                                                         input int unsigned py,
                                                         input int unsigned px,
                                                         input int unsigned w,
                                                         input int unsigned h);
        bit   top;
        bit   bot;
        bit   lft;
        bit   rgt;
        bit   any_zero;
        bit   any_set;
        mwf_pkg::pix_t ctr;
        mwf_pkg::pix_t mx;
        mwf_pkg::pix_t nb [$];
        top = (py == 0);
        bot = (py == h - 1);
        lft = (px == 0);
        rgt = (px == w - 1);
        ctr = p[4];
        mx = 8'd0;
        any_zero = 1'b0;
        any_set = 1'b0;
        if ((top || bot) && (lft || rgt)) begin
            nb.push_back(p[(top ? 6 : 0) + (lft ? 2 : 0)]);
        end else if (top || bot) begin
            for (int i = 0; i < 3; i++)
                nb.push_back(p[(top ? 6 : 0) + i]);
        end else if (lft || rgt) begin
            for (int i = 0; i < 3; i++)
                nb.push_back(p[i * 3 + (lft ? 2 : 0)]);
        end else begin
            for (int i = 0; i < 9; i++)
                if (i != 4)
                    nb.push_back(p[i]);
        end
        foreach (nb[i]) begin
            if (nb[i] == 8'd0)
                any_zero = 1'b1;
            else
                any_set = 1'b1;
            if (nb[i] > mx)
                mx = nb[i];
        end
        case (cur_mode)
            mwf_pkg::MODE_DILATE:  return (ctr == 8'd0 && any_set) ? mwf_pkg::PIX_MAX : ctr;
            mwf_pkg::MODE_ERODE:   return (ctr != 8'd0 && any_zero) ? 8'd0 : ctr;
            mwf_pkg::MODE_MAXFILL: return (ctr == 8'd0) ? mx : ctr;
            default:               return ctr;
        endcase
    endfunction

    function automatic mwf_pkg::result_t make_word(input mwf_pkg::pix_t v, input int unsigned r,
                                                   input int unsigned c, input bit done);
        mwf_pkg::result_t w;
        w.pixel      = v;
        w.row        = r[9:0];
        w.col        = c[9:0];
        w.run_last   = 1'b0;
        w.frame_done = done;
        return w;
    endfunction

    // expected words for one accepted pixel, then advance the raster position
    task automatic predict_pixel(input mwf_pkg::pix_t pin);
        int unsigned w;
        int unsigned h;
        int unsigned y;
        int unsigned x;
        int          n;
        mwf_pkg::pix_t    pt [9];
        mwf_pkg::result_t words [3];
        w = clamp_geom(width_reg);
        h = clamp_geom(height_reg);
        y = cur_row;
        x = cur_col;
        n = 0;
        if (x >= w)
            x = w - 1;
        if (y >= h)
            y = h - 1;
        for (int r = 0; r < 3; r++) begin
            nbhd[r * 3]     = nbhd[r * 3 + 1];
            nbhd[r * 3 + 1] = nbhd[r * 3 + 2];
        end
        nbhd[2] = older_row[x];
        nbhd[5] = prev_row[x];
        nbhd[8] = pin;
        if (y >= 1 && x >= 1) begin
            words[n] = make_word(neighborhood_value(nbhd, y - 1, x - 1, w, h), y - 1, x - 1, 1'b0);
            n++;
        end
        if (y >= 1 && x == w - 1) begin
            for (int r = 0; r < 3; r++) begin
                pt[r * 3]     = nbhd[r * 3 + 1];
                pt[r * 3 + 1] = nbhd[r * 3 + 2];
                pt[r * 3 + 2] = 8'd0;
            end
            words[n] = make_word(neighborhood_value(pt, y - 1, x, w, h), y - 1, x, 1'b0);
            n++;
        end
        if (y == h - 1) begin
            pt = '{nbhd[4], nbhd[5], (x + 1 < w) ? mwf_pkg::pix_t'(prev_row[x + 1]) : 8'd0,
                   nbhd[7], pin, 8'd0, 8'd0, 8'd0, 8'd0};
            words[n] = make_word(neighborhood_value(pt, y, x, w, h), y, x, x == w - 1);
            n++;
        end
        if (n > 0)
            words[n - 1].run_last = 1'b1;
        for (int i = 0; i < n; i++)
            expected_words.push_back(words[i]);
        older_row[x] = prev_row[x];
        prev_row[x] = pin;
        x++;
        if (x >= w) begin
            x = 0;
            y++;
            if (y >= h)
                y = 0;
        end
        cur_col = x;
        cur_row = y;
    endtask

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 70)
            return $urandom_range(1, 2);
        if (r < 92)
            return $urandom_range(3, 6);
        return $urandom_range(10, 40);
    endfunction

    // mostly background and saturated pixels so every morphology branch is hit
    function automatic mwf_pkg::pix_t next_pixel();
        int r;
        r = $urandom_range(0, 99);
        if (r < 45)
            return 8'd0;
        if (r < 55)
            return mwf_pkg::PIX_MAX;
        if (r < 60)
            return 8'd1;
        return mwf_pkg::pix_t'($urandom_range(1, 255));
    endfunction

    function automatic void note_error(input string msg);
        error_count++;
        if (error_count <= MAX_REPORTS)
            $display("ERROR at %0t: %s", $time, msg);
    endfunction

    always @(posedge aclk) begin
        if (rx_hold > 0) begin
            rx_hold <= rx_hold - 1;
            m_tready <= 1'b0;
        end else if (!rx_steady && $urandom_range(0, 3) == 0) begin
            rx_hold <= pick_gap() - 1;
            m_tready <= 1'b0;
        end else begin
            m_tready <= 1'b1;
        end
    end

    always @(posedge aclk) begin : result_check
        mwf_pkg::result_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (expected_words.size() == 0) begin
                note_error($sformatf("unexpected word pix %0d row %0d col %0d",
                                     m_tdata[7:0], m_tdata[17:8], m_tdata[27:18]));
            end else begin
                want = expected_words.pop_front();
                if (m_tdata[7:0] !== want.pixel || m_tdata[17:8] !== want.row ||
                    m_tdata[27:18] !== want.col || m_tlast !== want.run_last ||
                    m_tuser !== want.frame_done)
                    note_error($sformatf(
                        "exp pix %0d row %0d col %0d last %0b done %0b, got %0d %0d %0d %0b %0b",
                        want.pixel, want.row, want.col, want.run_last, want.frame_done,
                        m_tdata[7:0], m_tdata[17:8], m_tdata[27:18], m_tlast, m_tuser));
            end
        end
    end

    task automatic send_pixel(input mwf_pkg::pix_t v);
        int gap;
        s_tvalid <= 1'b1;
        s_tdata <= v;
        @(posedge aclk);
        while (!s_tready)
            @(posedge aclk);
        predict_pixel(v);
        gap = (!tx_steady && $urandom_range(0, 2) == 0) ? pick_gap() : 0;
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
    endtask

    task automatic run_pixels(input int count);
        for (int i = 0; i < count; i++)
            send_pixel(next_pixel());
        s_tvalid <= 1'b0;
    endtask

    task automatic wait_drained();
        while (expected_words.size() != 0)
            @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic apb_write(input logic [1:0] idx, input logic [31:0] val);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {idx, 2'b00};
        pwdata <= val;
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        case (idx)
            mwf_pkg::REG_OP_MODE: cur_mode = mwf_pkg::mode_t'(val[1:0]);
            mwf_pkg::REG_FRAME_WIDTH: begin
                width_reg = val[10:0];
                cur_row = 0;
                cur_col = 0;
            end
            mwf_pkg::REG_FRAME_HEIGHT: begin
                height_reg = val[10:0];
                cur_row = 0;
                cur_col = 0;
            end
            default: ;
        endcase
    endtask

    task automatic set_geometry(input logic [31:0] w, input logic [31:0] h);
        apb_write(mwf_pkg::REG_FRAME_WIDTH, w);
        apb_write(mwf_pkg::REG_FRAME_HEIGHT, h);
    endtask

    task automatic shuffle_idling();
        tx_steady = ($urandom_range(0, 3) == 0);
        rx_steady = ($urandom_range(0, 3) == 0);
    endtask

    // reset geometry 80x60, dilate
    task automatic test_reset_defaults();
        run_pixels(80 + 4);
        wait_drained();
    endtask

    task automatic test_directed_modes();
        set_geometry(32'd3, 32'd3);
        for (int m = 0; m < 3; m++) begin
            apb_write(mwf_pkg::REG_OP_MODE, 32'(directed_modes[m]));
            for (int i = 0; i < 9; i++)
                send_pixel(directed_frames[m][i]);
            s_tvalid <= 1'b0;
            wait_drained();
        end
    endtask

    task automatic test_geometry_limits();
        // below minimum, with junk above the register width
        apb_write(mwf_pkg::REG_OP_MODE, 32'hFFFF_FFFF);
        set_geometry(32'hFFFF_F802, 32'd0);
        run_pixels(2 * 9);
        wait_drained();
        apb_write(mwf_pkg::REG_OP_MODE, 32'(mwf_pkg::MODE_ERODE));
        set_geometry(32'd1, 32'd1);
        run_pixels(9 + 4);
        wait_drained();
        // widest rows, clamped from above the maximum
        shuffle_idling();
        apb_write(mwf_pkg::REG_OP_MODE, 32'(mwf_pkg::MODE_MAXFILL));
        set_geometry(32'd2047, 32'd3);
        run_pixels(12);
        wait_drained();
        // tallest frame
        shuffle_idling();
        apb_write(mwf_pkg::REG_OP_MODE, 32'(mwf_pkg::MODE_DILATE));
        set_geometry(32'd3, 32'd1025);
        run_pixels(15);
        wait_drained();
    endtask

    task automatic test_random_phases();
        int          sent;
        int          count;
        int unsigned w;
        int unsigned h;
        sent = 0;
        while (sent < 30) begin
            shuffle_idling();
            apb_write(mwf_pkg::REG_OP_MODE,
                      ($urandom() & 32'hFFFF_FFFC) | $urandom_range(0, 3));
            if ($urandom_range(0, 2) != 0) begin
                w = $urandom_range(3, 9);
                h = $urandom_range(3, 6);
                set_geometry(($urandom() & 32'hFFFF_F800) | w,
                             ($urandom() & 32'hFFFF_F800) | h);
            end
            count = $urandom_range(5, 40);
            run_pixels(count);
            sent += count;
            wait_drained();
        end
    endtask

    initial begin
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_reset_defaults();
        test_directed_modes();
        test_geometry_limits();
        test_random_phases();
        wait_drained();
        if (error_count == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

    initial begin
        #100ms;
        $display("*** FAILED ***");
        $finish;
    end

endmodule

[filelist.f]
design/mwf_pkg.sv
design/mwf_line_buf.sv
design/mwf_window.sv
design/mwf_out_queue.sv
design/morph_window_3x3_filter.sv
dv/morph_window_3x3_filter_tb.sv
